// ----- src/max_heap_priority_queue_top_assert.svh -----
// Assertion macros for the heap priority queue; only the sequencer (mhpq_ctrl) uses them.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MHPQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("heap queue assertion failed");
// Condition must never be true outside reset.
`define MHPQ_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("heap queue forbidden condition seen");
`else
`define MHPQ_ASSERT(lbl, clk, rst, prop)
`define MHPQ_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- src/mhpq_pkg.sv -----
// Types and constants of the max-heap priority queue.
package mhpq_pkg;

   localparam int VAL_W = 32;
   localparam int CNT_W = 9;
   localparam int IDX_W = CNT_W + 1;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_RM_ROOT,
      ST_RM_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_value;
      status_type              status;
      logic [CNT_W-1:0]        item_count;
      logic                    is_empty;
   } rsp_type;

endpackage

// ----- src/mhpq_ram.sv -----
// Heap store: one write port, one read port with registered read data.
module mhpq_ram
   import mhpq_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int ADDR_W  = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [VAL_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [VAL_W-1:0]  rd_data
);

   logic [VAL_W-1:0] mem_ff [ENTRIES];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mhpq_ctrl.sv -----
// Heap sequencer: insert with sift-up, remove with sift-down, result register.
`include "max_heap_priority_queue_top_assert.svh"
module mhpq_ctrl
   import mhpq_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int ADDR_W  = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  func_type                req_func,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [CNT_W-1:0]        capacity,
   output logic                    wr_en,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [VAL_W-1:0]        wr_data,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   input  logic [VAL_W-1:0]        rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp
);

   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] left_ff, left_in;
   logic signed [VAL_W-1:0] out_ff, out_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    req_fire;
   logic                    rsp_load;
   logic                    heap_full;
   logic signed [VAL_W-1:0] mem_val;
   logic [ADDR_W-1:0]       parent;
   logic [IDX_W-1:0]        left_idx;
   logic [IDX_W-1:0]        right_idx;
   logic [IDX_W-1:0]        count_ext;
   logic                    right_live;
   logic                    left_gt;
   logic                    right_gt;
   logic signed [VAL_W-1:0] best_val;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign heap_full = (count_ff >= capacity) || (count_ff >= ENTRIES_CNT);
   assign mem_val   = $signed(rd_data);
   assign parent    = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign left_idx  = (IDX_W'(pos_ff) << 1) | IDX_W'(1);
   assign right_idx = left_idx + IDX_W'(1);
   assign count_ext = IDX_W'(count_ff);
   assign right_live = right_idx < count_ext;
   // Ties between the children go to the left one.
   assign left_gt   = left_ff > val_ff;
   assign best_val  = left_gt ? left_ff : val_ff;
   assign right_gt  = right_live && (mem_val > best_val);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      left_ff   <= left_in;
      out_ff    <= out_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      left_in   = left_ff;
      out_in    = out_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = val_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_OK;
               out_in    = '0;
               if (req_func == FUNC_INSERT) begin
                  if (heap_full) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     val_in   = req_value;
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_RM_ROOT;
                  end
               end
            end
         end
         ST_UP_CHK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            // The hole moves up while the parent is strictly smaller.
            wr_en = 1'b1;
            if (mem_val < val_ff) begin
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = ST_UP_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RM_ROOT: begin
            out_in   = mem_val;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
            state_in = ST_RM_LAST;
         end
         ST_RM_LAST: begin
            val_in   = mem_val;
            pos_in   = '0;
            count_in = count_ff - CNT_W'(1);
            state_in = (count_ff == CNT_W'(1)) ? ST_DONE : ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            if (left_idx >= count_ext) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_idx[ADDR_W-1:0];
               state_in = ST_DN_RIGHT;
            end
         end
         ST_DN_RIGHT: begin
            left_in = mem_val;
            if (right_live) begin
               rd_en   = 1'b1;
               rd_addr = right_idx[ADDR_W-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (right_gt) begin
               wr_data  = rd_data;
               pos_in   = right_idx[ADDR_W-1:0];
               state_in = ST_DN_LEFT;
            end else if (left_gt) begin
               wr_data  = left_ff;
               pos_in   = left_idx[ADDR_W-1:0];
               state_in = ST_DN_LEFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_in.out_value  = out_ff;
         rsp_in.status     = status_ff;
         rsp_in.item_count = count_ff;
         rsp_in.is_empty   = (count_ff == '0);
         rsp_valid_in      = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `MHPQ_NEVER(a_count_bound, clock, reset, count_ff > ENTRIES_CNT)
   `MHPQ_ASSERT(a_write_live, clock, reset, wr_en |-> (IDX_W'(wr_addr) < count_ext))
   `MHPQ_ASSERT(a_fire_busy, clock, reset, req_fire |=> (state_ff != ST_IDLE))
   `MHPQ_ASSERT(a_full_cause, clock, reset, (rsp_load && status_ff == STATUS_FULL) |-> heap_full)

endmodule

// ----- src/max_heap_priority_queue_top.sv -----
// Insert: a parent read and a compare per level climbed (L, 0..8). Remove: root and last
// reads, then a left read, a right read and a compare per level descended (L, 0..7); a
// failed request goes straight to the result. The next request is taken in the cycle
// after the result is loaded; each sift level is bounded by the heap RAM's single read port.
// The output register lets a new request in while the previous result waits.
// Reset clears the element count and sets the capacity to 256; the store is not cleared.
module max_heap_priority_queue_top
   import mhpq_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] value
   input  logic [0:0]        req_tuser,   // [0] func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [47:0]       rsp_tdata,   // [31:0] out_value, [40:32] item_count, rest zero
   output logic [2:0]        rsp_tuser,   // [1:0] status, [2] is_empty
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_data
);

   // The count cannot pass the widest capacity the register can express.
   localparam int STORE_DEPTH = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic [CNT_W-1:0]  capacity_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [VAL_W-1:0]  rd_data;
   rsp_type           rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   mhpq_ram #(
      .ENTRIES (STORE_DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mhpq_ctrl #(
      .ENTRIES (STORE_DEPTH),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (func_type'(req_tuser[0])),
      .req_value ($signed(req_tdata)),
      .capacity  (capacity_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.item_count, rsp.out_value};
   assign rsp_tuser = {rsp.is_empty, rsp.status};

endmodule
